>>> sv/ftt_pkg.sv
// ----------------------------------------------------------------------------
// ftt_pkg
// Shared types and constants for the timed fault tag table.
// ----------------------------------------------------------------------------
package ftt_pkg;

  localparam int unsigned TAG_W  = 24;
  localparam int unsigned CYC_W  = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned USED_W = 6;
  localparam int unsigned STAT_W = 3;

  // Tags below this value are reserved and never reported as open.
  localparam logic [TAG_W-1:0] MIN_TAG = 24'h000100;

  typedef enum logic [1:0] {
    CMD_OPEN       = 2'd0,
    CMD_CLOSE      = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_CLOSE_STEP = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_TAG   = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_CLOSED    = 3'd5
  } status_t;

  // One table entry as it is kept in memory.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             open;
    logic [CYC_W-1:0] open_cycle;
    logic [CYC_W-1:0] countdown;
    logic             armed;
  } entry_t;

endpackage

>>> sv/ftt_mem.sv
// ----------------------------------------------------------------------------
// ftt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftt_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  output ftt_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ftt_pkg::entry_t wr_data
);

  ftt_pkg::entry_t mem [DEPTH];
  ftt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/ftt_ctrl.sv
// ----------------------------------------------------------------------------
// ftt_ctrl
// Command sequencer: scans the entry store for a tag, then reads, modifies
// and writes back the matching entry, appends an unknown tag on open, or moves the last entry on delete.
// ----------------------------------------------------------------------------
module ftt_ctrl #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [ftt_pkg::TAG_W-1:0]     in_tag,
  input  logic [ftt_pkg::CYC_W-1:0]     in_cycle_value,
  input  logic [ftt_pkg::CYC_W-1:0]     in_now,
  output logic                          out_valid,
  output logic                          out_is_open,
  output logic [ftt_pkg::STAT_W-1:0]    out_status,
  output logic [ftt_pkg::SLOT_W-1:0]    out_slot,
  output logic [ftt_pkg::USED_W-1:0]    out_entries_used,
  output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
  input  ftt_pkg::entry_t               mem_rd_data,
  output logic                          mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
  output ftt_pkg::entry_t               mem_wr_data
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_LAST,
    S_MOVE
  } state_t;

  state_t                       state_r;
  ftt_pkg::cmd_t                cmd_r;
  logic [ftt_pkg::TAG_W-1:0]    tag_r;
  logic [ftt_pkg::CYC_W-1:0]    val_r;
  logic [ftt_pkg::CYC_W-1:0]    now_r;
  logic [CW-1:0]                used_r;
  logic [CW-1:0]                issue_r;
  logic                         pend_vld_r;
  logic [IW-1:0]                pend_idx_r;
  logic                         hit_r;
  logic [IW-1:0]                slot_r;
  ftt_pkg::entry_t              rec_r;
  logic                         out_valid_r;
  logic                         out_is_open_r;
  ftt_pkg::status_t             out_status_r;
  logic [IW-1:0]                out_slot_r;

  ftt_pkg::cmd_t                in_cmd_e;
  logic                         match;
  logic [IW-1:0]                last_idx;
  logic                         open_ok;
  logic [ftt_pkg::CYC_W-1:0]    cnt_sel;
  ftt_pkg::entry_t              new_rec;

  assign in_cmd_e = ftt_pkg::cmd_t'(in_cmd);
  assign match    = pend_vld_r && (mem_rd_data.tag == tag_r);
  assign last_idx = IW'(used_r - CW'(1));
  assign open_ok  = (tag_r >= ftt_pkg::MIN_TAG) && rec_r.open && (rec_r.open_cycle <= now_r);
  // A countdown that is not yet armed starts from the given length.
  assign cnt_sel  = rec_r.armed ? rec_r.countdown : val_r;

  always_comb begin
    new_rec            = rec_r;
    new_rec.tag        = tag_r;
    new_rec.open       = 1'b1;
    new_rec.open_cycle = val_r;
    new_rec.countdown  = '0;
    new_rec.armed      = 1'b0;
  end

  always_comb begin
    mem_rd_addr = issue_r[IW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = slot_r;
    mem_wr_data = rec_r;
    case (state_r)
      S_LAST: begin
        mem_rd_addr = last_idx;
      end
      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
      end
      S_ACT: begin
        case (cmd_r)
          ftt_pkg::CMD_OPEN: begin
            mem_wr_en = 1'b1;
            if (hit_r) begin
              mem_wr_data.open       = 1'b1;
              mem_wr_data.open_cycle = val_r;
            end else begin
              mem_wr_addr = used_r[IW-1:0];
              mem_wr_data = new_rec;
            end
          end
          ftt_pkg::CMD_CLOSE_STEP: begin
            if (!open_ok) begin
              mem_wr_en         = rec_r.armed;
              mem_wr_data.armed = 1'b0;
            end else begin
              mem_wr_en = 1'b1;
              if (cnt_sel == '0) begin
                mem_wr_data.open      = 1'b0;
                mem_wr_data.armed     = 1'b0;
                mem_wr_data.countdown = cnt_sel;
              end else begin
                mem_wr_data.armed     = 1'b1;
                mem_wr_data.countdown = cnt_sel - 32'd1;
              end
            end
          end
          default: begin
            mem_wr_en = 1'b0;
          end
        endcase
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      issue_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r         <= in_cmd_e;
            tag_r         <= in_tag;
            val_r         <= in_cycle_value;
            now_r         <= in_now;
            issue_r       <= '0;
            pend_vld_r    <= 1'b0;
            out_is_open_r <= 1'b0;
            out_slot_r    <= '0;
            if (in_cmd_e == ftt_pkg::CMD_OPEN && used_r == CW'(DEPTH)) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ftt_pkg::ST_FULL;
            end else if (in_cmd_e == ftt_pkg::CMD_QUERY && in_tag < ftt_pkg::MIN_TAG) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ftt_pkg::ST_BAD_TAG;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Reads are issued one slot ahead of the compare.
          if (issue_r < used_r) begin
            issue_r    <= issue_r + CW'(1);
            pend_vld_r <= 1'b1;
            pend_idx_r <= issue_r[IW-1:0];
          end else begin
            pend_vld_r <= 1'b0;
          end
          if (match) begin
            hit_r  <= 1'b1;
            slot_r <= pend_idx_r;
            rec_r  <= mem_rd_data;
            if (cmd_r == ftt_pkg::CMD_CLOSE) begin
              if (pend_idx_r != last_idx) begin
                state_r <= S_LAST;
              end else begin
                used_r       <= used_r - CW'(1);
                out_valid_r  <= 1'b1;
                out_status_r <= ftt_pkg::ST_OK;
                out_slot_r   <= pend_idx_r;
                state_r      <= S_IDLE;
              end
            end else begin
              state_r <= S_ACT;
            end
          end else if (!pend_vld_r && issue_r >= used_r) begin
            if (cmd_r == ftt_pkg::CMD_OPEN) begin
              hit_r   <= 1'b0;
              state_r <= S_ACT;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= ftt_pkg::ST_NOT_FOUND;
              state_r      <= S_IDLE;
            end
          end
        end
        S_ACT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ftt_pkg::ST_OK;
          out_slot_r   <= slot_r;
          state_r      <= S_IDLE;
          case (cmd_r)
            ftt_pkg::CMD_OPEN: begin
              if (!hit_r) begin
                used_r     <= used_r + CW'(1);
                out_slot_r <= used_r[IW-1:0];
              end
            end
            ftt_pkg::CMD_QUERY: begin
              out_is_open_r <= rec_r.open && (rec_r.open_cycle <= now_r);
            end
            ftt_pkg::CMD_CLOSE_STEP: begin
              out_is_open_r <= open_ok;
              if (!open_ok) begin
                if (rec_r.armed) begin
                  out_status_r <= ftt_pkg::ST_CANCELLED;
                end
              end else if (cnt_sel == '0) begin
                out_status_r <= ftt_pkg::ST_CLOSED;
              end
            end
            default: begin
              out_status_r <= ftt_pkg::ST_OK;
            end
          endcase
        end
        S_LAST: begin
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          used_r       <= used_r - CW'(1);
          out_valid_r  <= 1'b1;
          out_status_r <= ftt_pkg::ST_OK;
          out_slot_r   <= slot_r;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_is_open      = out_is_open_r;
  assign out_status       = out_status_r;
  assign out_slot         = ftt_pkg::SLOT_W'(out_slot_r);
  // The count only changes when an item finishes, so it is stable while shown.
  assign out_entries_used = ftt_pkg::USED_W'(used_r);

endmodule

>>> sv/timed_fault_tag_table_top.sv
// ----------------------------------------------------------------------------
// timed_fault_tag_table_top
// Table of fault-injection tags with timed open and countdown close.
// ----------------------------------------------------------------------------
//
//   channel   ports                                      handshake
//   -------   -----------------------------------------  -------------------
//   input     in_cmd, in_tag, in_cycle_value, in_now     start high, busy low
//   result    out_is_open, out_status, out_slot,         out_valid, 1 cycle
//             out_entries_used
//
// How long an item takes is set by the linear tag scan through the single read
// port of the entry store, so it grows with the slot of the tag that is found.
// A delete of any entry but the last also reads the last entry and moves it
// into the freed slot before its result is shown.
// Reset is synchronous; the entry store needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
module timed_fault_tag_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [ftt_pkg::TAG_W-1:0]     in_tag,
  input  logic [ftt_pkg::CYC_W-1:0]     in_cycle_value,
  input  logic [ftt_pkg::CYC_W-1:0]     in_now,
  output logic                          out_valid,
  output logic                          out_is_open,
  output logic [ftt_pkg::STAT_W-1:0]    out_status,
  output logic [ftt_pkg::SLOT_W-1:0]    out_slot,
  output logic [ftt_pkg::USED_W-1:0]    out_entries_used
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic [IW-1:0]   mem_rd_addr;
  ftt_pkg::entry_t mem_rd_data;
  logic            mem_wr_en;
  logic [IW-1:0]   mem_wr_addr;
  ftt_pkg::entry_t mem_wr_data;

  ftt_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_tag           (in_tag),
    .in_cycle_value   (in_cycle_value),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_is_open      (out_is_open),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_entries_used (out_entries_used),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data)
  );

  ftt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

>>> verif/timed_fault_tag_table_top_tb.sv
// ----------------------------------------------------------------------------
// timed_fault_tag_table_top_tb
// Self-checking testbench for the timed fault tag table.
//
// A scoreboard keeps its own copy of the tag table. For every accepted item it
// computes the expected result and queues it, and it checks each result strobe
// against the oldest queued result. A short directed sequence covers the
// corner cases. Random traffic then fills the table and drains it again,
// drawing tags from a small pool so that they match, with countdown bursts
// that repeat one tag. Random idle gaps on the command side vary the timing.
// ----------------------------------------------------------------------------
import ftt_pkg::*;

class fault_tag_scoreboard #(int unsigned DEPTH = 32);

  typedef struct {
    logic              is_open;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used;
  } tag_result_t;

  logic [TAG_W-1:0] tag_of[DEPTH];
  bit               open_of[DEPTH];
  logic [CYC_W-1:0] open_cycle[DEPTH];
  logic [CYC_W-1:0] count_left[DEPTH];
  bit               armed_of[DEPTH];
  int unsigned      used;
  tag_result_t      pending[$];
  int unsigned      errors;
  int unsigned      checked;
  int unsigned      status_hits[6];

  function new();
    for (int i = 0; i < DEPTH; i++) clear_slot(i);
    used    = 0;
    errors  = 0;
    checked = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  function void clear_slot(int s);
    tag_of[s]     = '0;
    open_of[s]    = 1'b0;
    open_cycle[s] = '0;
    count_left[s] = '0;
    armed_of[s]   = 1'b0;
  endfunction

  // Slots are packed from 0, so the first match in the used range wins.
  function int find_slot(logic [TAG_W-1:0] tag);
    for (int i = 0; i < used; i++) begin
      if (tag_of[i] == tag) return i;
    end
    return -1;
  endfunction

  function bit open_by(logic [TAG_W-1:0] tag, int s, logic [CYC_W-1:0] now);
    return (tag >= MIN_TAG) && open_of[s] && (open_cycle[s] <= now);
  endfunction

  function void note_item(cmd_t cmd, logic [TAG_W-1:0] tag, logic [CYC_W-1:0] val,
                          logic [CYC_W-1:0] now);
    tag_result_t r;
    int          s;
    int          last;
    r.is_open = 1'b0;
    r.status  = ST_OK;
    r.slot    = '0;
    case (cmd)
      CMD_OPEN: begin
        if (used >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          s = find_slot(tag);
          if (s < 0) begin
            s             = used;
            tag_of[s]     = tag;
            count_left[s] = '0;
            armed_of[s]   = 1'b0;
            used++;
          end
          open_of[s]    = 1'b1;
          open_cycle[s] = val;
          r.slot        = SLOT_W'(s);
        end
      end
      CMD_CLOSE: begin
        s = find_slot(tag);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // The last entry fills the hole so the table stays packed.
          last = used - 1;
          if (s != last) begin
            tag_of[s]     = tag_of[last];
            open_of[s]    = open_of[last];
            open_cycle[s] = open_cycle[last];
            count_left[s] = count_left[last];
            armed_of[s]   = armed_of[last];
          end
          clear_slot(last);
          used--;
          r.slot = SLOT_W'(s);
        end
      end
      CMD_QUERY: begin
        if (tag < MIN_TAG) begin
          r.status = ST_BAD_TAG;
        end else begin
          s = find_slot(tag);
          if (s < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.is_open = open_by(tag, s, now);
            r.slot    = SLOT_W'(s);
          end
        end
      end
      default: begin
        s = find_slot(tag);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.slot = SLOT_W'(s);
          if (!open_by(tag, s, now)) begin
            if (armed_of[s]) begin
              armed_of[s] = 1'b0;
              r.status    = ST_CANCELLED;
            end
          end else begin
            r.is_open = 1'b1;
            if (!armed_of[s]) begin
              armed_of[s]   = 1'b1;
              count_left[s] = val;
            end
            if (count_left[s] == '0) begin
              open_of[s]  = 1'b0;
              armed_of[s] = 1'b0;
              r.status    = ST_CLOSED;
            end else begin
              count_left[s] = count_left[s] - 1'b1;
            end
          end
        end
      end
    endcase
    r.used = USED_W'(used);
    status_hits[r.status]++;
    pending.push_back(r);
  endfunction

  function void check_result(logic is_open, logic [STAT_W-1:0] status,
                             logic [SLOT_W-1:0] slot, logic [USED_W-1:0] used_now);
    tag_result_t want;
    if (pending.size() == 0) begin
      $error("Result with no item outstanding: status %0d, slot %0d", status, slot);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (is_open !== want.is_open) begin
      $error("is_open mismatch: expected %0d, got %0d", want.is_open, is_open);
      errors++;
    end
    if (status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, status);
      errors++;
    end
    if (slot !== want.slot) begin
      $error("slot mismatch: expected %0d, got %0d", want.slot, slot);
      errors++;
    end
    if (used_now !== want.used) begin
      $error("entries_used mismatch: expected %0d, got %0d", want.used, used_now);
      errors++;
    end
  endfunction

endclass

module timed_fault_tag_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned POOL_SIZE    = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 8;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic [1:0]        in_cmd         = '0;
  logic [TAG_W-1:0]  in_tag         = '0;
  logic [CYC_W-1:0]  in_cycle_value = '0;
  logic [CYC_W-1:0]  in_now         = '0;
  logic              busy;
  logic              out_valid;
  logic              out_is_open;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [USED_W-1:0] out_entries_used;

  fault_tag_scoreboard #(TABLE_DEPTH) sb;

  logic [TAG_W-1:0] tag_pool[POOL_SIZE];
  logic [CYC_W-1:0] clock_now;
  bit               quiet;
  bit               grow;
  int unsigned      items_sent;
  int unsigned      first_random;
  int unsigned      cycles = 0;

  timed_fault_tag_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_tag          (in_tag),
    .in_cycle_value  (in_cycle_value),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_is_open     (out_is_open),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entries_used(out_entries_used)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("Run stopped after %0d cycles with %0d results outstanding",
             cycles, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_is_open, out_status, out_slot, out_entries_used);
    end
  end

  // Presents one item, holds it until the block takes it, then may idle.
  task automatic send_item(cmd_t cmd, logic [TAG_W-1:0] tag, logic [CYC_W-1:0] val,
                           logic [CYC_W-1:0] now);
    int unsigned gap;
    in_cmd         <= cmd;
    in_tag         <= tag;
    in_cycle_value <= val;
    in_now         <= now;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(cmd, tag, val, now);
    items_sent++;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 25) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return TAG_W'($urandom);
    if (r < 60 && sb.used > 0) return sb.tag_of[$urandom_range(0, sb.used - 1)];
    return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic random_op(bit filling);
    cmd_t             cmd;
    logic [TAG_W-1:0] tag;
    logic [CYC_W-1:0] val;
    int unsigned      pick;
    int unsigned      burst;
    // A small share of items is pure noise on every field.
    if ($urandom_range(0, 19) == 0) begin
      send_item(cmd_t'(2'($urandom_range(0, 3))), TAG_W'($urandom), $urandom, $urandom);
      return;
    end
    pick = $urandom_range(0, 99);
    if (filling) begin
      cmd = (pick < 50) ? CMD_OPEN : (pick < 60) ? CMD_CLOSE :
            (pick < 75) ? CMD_QUERY : CMD_CLOSE_STEP;
    end else begin
      cmd = (pick < 15) ? CMD_OPEN : (pick < 50) ? CMD_CLOSE :
            (pick < 70) ? CMD_QUERY : CMD_CLOSE_STEP;
    end
    tag = pick_tag();
    if ($urandom_range(0, 32) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 6);
    pick = $urandom_range(0, 99);
    case (cmd)
      CMD_OPEN: begin
        // Open cycles mostly land just before or just after the current cycle.
        val = (pick < 70) ? clock_now - 32'd8 + $urandom_range(0, 16) :
              (pick < 80) ? '0 : (pick < 90) ? '1 : $urandom;
      end
      CMD_CLOSE_STEP: begin
        val = (pick < 70) ? CYC_W'($urandom_range(0, 3)) : (pick < 85) ? $urandom : '0;
      end
      default: val = $urandom;
    endcase
    burst = (cmd == CMD_CLOSE_STEP && $urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : 1;
    repeat (burst) begin
      send_item(cmd, tag, val, clock_now);
      clock_now = clock_now + $urandom_range(0, 3);
    end
  endtask

  initial begin
    sb         = new();
    clock_now  = $urandom_range(100, 5000);
    quiet      = 1'b0;
    items_sent = 0;
    tag_pool[0] = '0;
    tag_pool[1] = 24'h0000FF;
    tag_pool[2] = MIN_TAG;
    tag_pool[3] = '1;
    for (int i = 4; i < 8; i++) tag_pool[i] = TAG_W'($urandom_range(0, 255));
    for (int i = 8; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom_range(256, 24'hFFFFFF));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: reserved tag, unknown tags on every lookup command.
    send_item(CMD_QUERY,      24'h000000, 32'd0,        32'd0);
    send_item(CMD_QUERY,      24'hFFFFFF, 32'd0,        32'hFFFFFFFF);
    send_item(CMD_CLOSE,      24'hABCDEF, 32'hFFFFFFFF, 32'd0);
    send_item(CMD_CLOSE_STEP, 24'h123456, 32'd3,        32'd100);
    // Extreme tags and cycles; the open test is exact at the boundary.
    send_item(CMD_OPEN,       24'h000000, 32'd0,        32'd0);
    send_item(CMD_OPEN,       24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_QUERY,      24'hFFFFFF, 32'd0,        32'hFFFFFFFE);
    send_item(CMD_QUERY,      24'hFFFFFF, 32'd0,        32'hFFFFFFFF);
    send_item(CMD_CLOSE_STEP, 24'h000000, 32'd7,        32'hFFFFFFFF);
    send_item(CMD_QUERY,      24'h0000FF, 32'd0,        32'd0);
    // Countdown of two: not yet open, armed, stepped, then closed.
    send_item(CMD_OPEN,       MIN_TAG,    32'd5,        32'd0);
    send_item(CMD_CLOSE_STEP, MIN_TAG,    32'd2,        32'd4);
    send_item(CMD_CLOSE_STEP, MIN_TAG,    32'd2,        32'd5);
    send_item(CMD_CLOSE_STEP, MIN_TAG,    32'd9,        32'd6);
    send_item(CMD_CLOSE_STEP, MIN_TAG,    32'd9,        32'd7);
    send_item(CMD_QUERY,      MIN_TAG,    32'd0,        32'd8);
    // A zero countdown closes on the first step.
    send_item(CMD_OPEN,       24'h000200, 32'd0,        32'd0);
    send_item(CMD_CLOSE_STEP, 24'h000200, 32'd0,        32'd0);
    // Reopening later leaves the countdown armed, so the next step cancels it.
    send_item(CMD_OPEN,       24'h000300, 32'd10,       32'd10);
    send_item(CMD_CLOSE_STEP, 24'h000300, 32'hFFFFFFFF, 32'd10);
    send_item(CMD_OPEN,       24'h000300, 32'd100,      32'd20);
    send_item(CMD_CLOSE_STEP, 24'h000300, 32'd1,        32'd50);
    // Deletes that move the last entry down, then one of the last entry itself.
    send_item(CMD_CLOSE,      24'h000000, 32'd0,        32'd0);
    send_item(CMD_CLOSE,      24'h000300, 32'd0,        32'd0);
    send_item(CMD_CLOSE,      MIN_TAG,    32'd0,        32'd0);

    // Random traffic alternates between filling the table and draining it.
    grow         = 1'b1;
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      quiet = (items_sent - first_random >= 500) && (items_sent - first_random < 800);
      if (grow && sb.used == TABLE_DEPTH && $urandom_range(0, 7) == 0) grow = 1'b0;
      else if (!grow && sb.used < 3) grow = 1'b1;
      random_op(grow);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results: %0d refused on a full table,",
             items_sent, sb.checked, sb.status_hits[ST_FULL]);
    $display("%0d unknown tags, %0d reserved tags, %0d countdowns cancelled, %0d closed.",
             sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_BAD_TAG],
             sb.status_hits[ST_CANCELLED], sb.status_hits[ST_CLOSED]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
